// ===== rtl/irrfd_pkg.sv =====
// Shared constants and types for the infrared remote frame decoder.
package irrfd_pkg;

  // Field widths
  localparam int TICKS_W  = 16;
  localparam int US_W     = 15;
  localparam int CODE_W   = 8;
  localparam int BTN_W    = 3;
  localparam int CFG_W    = 15;
  localparam int CFG_AW   = 3;
  localparam int IN_TDW   = 16;
  localparam int OUT_TDW  = 16;

  // Interval bookkeeping
  localparam int MAX_INTERVALS_DEF = 50;
  localparam int FIRST_BIT_IDX     = 17;
  localparam int BIT_COUNT         = 8;

  // Input kinds carried on tuser
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_LEADER_MIN = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LEADER_MAX = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CODE_LEFT  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CODE_RIGHT = 3'd5;
  localparam logic [CFG_AW-1:0] REG_CODE_UP    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CODE_DOWN  = 3'd7;

  // Register reset values
  localparam logic [US_W-1:0]   RST_LEADER_MIN = 15'd10000;
  localparam logic [US_W-1:0]   RST_LEADER_MAX = 15'd15000;
  localparam logic [US_W-1:0]   RST_ONE_MIN    = 15'd2000;
  localparam logic [US_W-1:0]   RST_ONE_MAX    = 15'd2300;
  localparam logic [CODE_W-1:0] RST_CODE_LEFT  = 8'd8;
  localparam logic [CODE_W-1:0] RST_CODE_RIGHT = 8'd90;
  localparam logic [CODE_W-1:0] RST_CODE_UP    = 8'd24;
  localparam logic [CODE_W-1:0] RST_CODE_DOWN  = 8'd82;

  // Button codes
  localparam logic [BTN_W-1:0] BTN_NONE  = 3'd0;
  localparam logic [BTN_W-1:0] BTN_LEFT  = 3'd1;
  localparam logic [BTN_W-1:0] BTN_RIGHT = 3'd2;
  localparam logic [BTN_W-1:0] BTN_UP    = 3'd3;
  localparam logic [BTN_W-1:0] BTN_DOWN  = 3'd4;

  // One decoded frame as it leaves the block
  typedef struct packed {
    logic              frame_valid;
    logic [BTN_W-1:0]  button;
    logic [CODE_W-1:0] command_byte;
  } result_t;

endpackage

// ===== rtl/ir_remote_frame_decoder.sv =====
// Top level of the NEC-style infrared remote frame decoder.
//
//  channel  dir  handshake            tdata (low bit up)                tuser
//  in_      in   in_tvalid/in_tready  [15:0] elapsed_ticks              [0] cmd
//  out_     out  out_tvalid/out_tready [7:0] command_byte, [10:8] button [0] frame_valid
//  cfg_     in   cfg_wr_en            cfg_addr = register index, cfg_wdata = value
//
// One request per cycle while in_tready is high: an edge updates the frame
// state in the cycle it is taken, a timeout writes its result into the output
// register at that edge, or into the skid entry if the output register is held.
// Output register plus one skid entry: in_tready is low only while the skid
// entry is full, so requests keep flowing while one result waits downstream.
// rst_n is synchronous and active low; it restores the register defaults
// and disarms the decoder. No clearing pass is needed.
module ir_remote_frame_decoder
  import irrfd_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // [15:0] elapsed_ticks
  input  logic               in_tuser,   // [0] cmd
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TDW-1:0] out_tdata,  // [7:0] command_byte, [10:8] button, zero pad
  output logic               out_tuser,  // [0] frame_valid
  // configuration
  input  logic               cfg_wr_en,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_INTERVALS);
  localparam logic [CNT_W-1:0] BIT_FIRST = CNT_W'(FIRST_BIT_IDX);
  localparam logic [CNT_W-1:0] BIT_END   = CNT_W'(FIRST_BIT_IDX + BIT_COUNT);

  // ---------------------------------------------------------------- config
  logic [US_W-1:0]   leader_min_r, leader_max_r, one_min_r, one_max_r;
  logic [CODE_W-1:0] code_left_r, code_right_r, code_up_r, code_down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_min_r <= RST_LEADER_MIN;
      leader_max_r <= RST_LEADER_MAX;
      one_min_r    <= RST_ONE_MIN;
      one_max_r    <= RST_ONE_MAX;
      code_left_r  <= RST_CODE_LEFT;
      code_right_r <= RST_CODE_RIGHT;
      code_up_r    <= RST_CODE_UP;
      code_down_r  <= RST_CODE_DOWN;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LEADER_MIN: leader_min_r <= cfg_wdata;
        REG_LEADER_MAX: leader_max_r <= cfg_wdata;
        REG_ONE_MIN:    one_min_r    <= cfg_wdata;
        REG_ONE_MAX:    one_max_r    <= cfg_wdata;
        REG_CODE_LEFT:  code_left_r  <= cfg_wdata[CODE_W-1:0];
        REG_CODE_RIGHT: code_right_r <= cfg_wdata[CODE_W-1:0];
        REG_CODE_UP:    code_up_r    <= cfg_wdata[CODE_W-1:0];
        REG_CODE_DOWN:  code_down_r  <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- frame state
  logic              armed_r, armed_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [US_W-1:0]   leader_r, leader_nxt;
  logic [CODE_W-1:0] bits_r, bits_nxt;   // stale bits survive a timeout
  logic [BTN_W-1:0]  last_btn_r, last_btn_nxt;

  // output register and skid entry
  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  logic             in_acc, edge_acc, tmo_acc, pop;
  logic [US_W-1:0]  us;
  logic             is_one, in_bits, leader_ok;
  logic [2:0]       bit_sel;
  logic [BTN_W-1:0] btn_map;
  result_t          res;

  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign edge_acc  = in_acc && (in_tuser == CMD_EDGE);
  assign tmo_acc   = in_acc && (in_tuser == CMD_TIMEOUT);
  assign pop       = out_vld_r && out_tready;

  // half-microsecond ticks down to microseconds
  assign us      = in_tdata[TICKS_W-1:1];
  assign is_one  = (us >= one_min_r) && (us <= one_max_r);
  assign in_bits = (count_r >= BIT_FIRST) && (count_r < BIT_END);
  assign bit_sel = 3'(count_r - BIT_FIRST);

  assign leader_ok = (leader_r >= leader_min_r) && (leader_r <= leader_max_r);

  // first matching code wins, left to down
  always_comb begin
    priority if (bits_r == code_left_r)  btn_map = BTN_LEFT;
    else if      (bits_r == code_right_r) btn_map = BTN_RIGHT;
    else if      (bits_r == code_up_r)    btn_map = BTN_UP;
    else if      (bits_r == code_down_r)  btn_map = BTN_DOWN;
    else                                  btn_map = BTN_NONE;
  end

  always_comb begin
    armed_nxt    = armed_r;
    count_nxt    = count_r;
    leader_nxt   = leader_r;
    bits_nxt     = bits_r;
    last_btn_nxt = last_btn_r;

    res.frame_valid  = leader_ok;
    res.command_byte = leader_ok ? bits_r : '0;
    res.button       = leader_ok ? btn_map : last_btn_r;

    if (edge_acc) begin
      if (!armed_r) begin
        armed_nxt = 1'b1;               // first edge only arms
      end else if (count_r < CNT_MAX) begin
        if (count_r == '0) begin
          leader_nxt = us;
        end else if (in_bits) begin
          bits_nxt[bit_sel] = is_one;
        end
        count_nxt = count_r + 1'b1;     // saturates at the limit by the guard
      end
    end else if (tmo_acc) begin
      armed_nxt    = 1'b0;
      count_nxt    = '0;
      leader_nxt   = '0;
      last_btn_nxt = res.button;        // invalid frame keeps the old button
    end
  end

  // result path: out register first, skid only when out is held
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (tmo_acc) begin
      if (!out_vld_r || pop) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      count_r    <= '0;
      leader_r   <= '0;
      bits_r     <= '0;
      last_btn_r <= BTN_NONE;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      armed_r    <= armed_nxt;
      count_r    <= count_nxt;
      leader_r   <= leader_nxt;
      bits_r     <= bits_nxt;
      last_btn_r <= last_btn_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.frame_valid;
  assign out_tdata  = {(OUT_TDW - BTN_W - CODE_W)'(0), out_r.button, out_r.command_byte};

  // ---------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry full while output register empty");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("interval count past its limit");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tmo_acc |=> (!armed_r && count_r == '0 && leader_r == '0))
    else $error("frame state not cleared after timeout");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.frame_valid) |-> (out_r.command_byte == '0))
    else $error("invalid frame carries a command byte");

endmodule
